>>> hdl/aht_pkg.sv
// Shared constants, types and helpers for the averaged hysteresis threshold block.
package aht_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 20;
    localparam int WIN_W      = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 16;
    localparam int POS_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = POS_W + 1;
    localparam int CMP_W      = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int DCNT_W     = $clog2(SUM_W + 1);

    typedef logic [SAMPLE_W-1:0] t_level;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [WIN_W-1:0]    t_win;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [CMP_W-1:0]    t_cmp;
    typedef logic [MODE_W-1:0]   t_mode;

    localparam t_level LEVEL_MAX = '1;
    localparam t_sum   SUM_MAX   = '1;

    // Classification modes
    localparam t_mode MODE_NONE   = 2'd0;
    localparam t_mode MODE_SINGLE = 2'd1;
    localparam t_mode MODE_HYST   = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ON   = 3'd0,
        CFG_WINDOW_SIZE = 3'd1,
        CFG_EVENT_MODE  = 3'd2,
        CFG_SINGLE_THR  = 3'd3,
        CFG_LOW_THR     = 3'd4,
        CFG_HIGH_THR    = 3'd5,
        CFG_INIT_STATE  = 3'd6
    } t_cfg_idx;

    // Clamp the programmed window to 1..MAX_WINDOW
    function automatic t_win eff_window(input t_win w);
        t_win r;
        if (w == '0) begin
            r = t_win'(1);
        end else if (t_cmp'(w) > t_cmp'(MAX_WINDOW)) begin
            r = t_win'(MAX_WINDOW);
        end else begin
            r = w;
        end
        return r;
    endfunction

endpackage

>>> hdl/aht_in_if.sv
// Input channel: command and raw sample with valid/ready handshake.
interface aht_in_if;
    import aht_pkg::*;

    logic   valid;
    logic   ready;
    logic   cmd;
    t_level sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

>>> hdl/aht_out_if.sv
// Output channel: level, switch state and changed flag with valid/ready handshake.
interface aht_out_if;
    import aht_pkg::*;

    logic   valid;
    logic   ready;
    t_level level;
    logic   switch_state;
    logic   changed;

    modport source (output valid, output level, output switch_state, output changed,
                    input ready);
    modport sink   (input valid, input level, input switch_state, input changed,
                    output ready);
endinterface

>>> hdl/aht_ring.sv
// Sample ring with running sum: one update per filtered item.
module aht_ring (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_upd,
    input  aht_pkg::t_level i_sample,
    input  aht_pkg::t_win   i_window,
    output aht_pkg::t_sum   o_sum
);
    import aht_pkg::*;

    typedef logic [SUM_W:0] t_sum_x;

    t_level                r_ring [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] r_vld;
    t_pos                  r_pos;
    t_sum                  r_sum;

    t_cnt   pos_inc;
    t_pos   pos_nxt;
    t_level old_val;
    t_sum   sum_sub;
    t_sum_x sum_add;
    t_sum   n_sum;

    // Advance position, wrap at the window edge
    always_comb begin
        pos_inc = t_cnt'(r_pos) + t_cnt'(1);
        if (t_cmp'(pos_inc) >= t_cmp'(i_window)) begin
            pos_nxt = '0;
        end else begin
            pos_nxt = pos_inc[POS_W-1:0];
        end
    end

    // Drop the oldest entry with clamp at zero, add the new one, saturate
    always_comb begin
        old_val = r_vld[pos_nxt] ? r_ring[pos_nxt] : '0;
        sum_sub = (r_sum < t_sum'(old_val)) ? '0 : (r_sum - t_sum'(old_val));
        sum_add = t_sum_x'(sum_sub) + t_sum_x'(i_sample);
        n_sum   = (sum_add > t_sum_x'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
    end

    // Control state: position, sum, entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
            r_vld <= '0;
        end else if (i_upd) begin
            r_pos          <= pos_nxt;
            r_sum          <= n_sum;
            r_vld[pos_nxt] <= 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            r_ring[pos_nxt] <= i_sample;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> hdl/aht_div.sv
// Restoring divider: one quotient bit per cycle, sum by window size.
module aht_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  aht_pkg::t_sum i_dividend,
    input  aht_pkg::t_win i_divisor,
    output logic          o_done,
    output aht_pkg::t_sum o_quotient
);
    import aht_pkg::*;

    typedef logic [WIN_W:0] t_trial;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    t_win              r_dsr;
    t_win              r_rem;
    t_sum              r_quo;

    t_trial trial;
    logic   q_bit;
    t_win   n_rem;

    // Shift in the next dividend bit and try one subtract
    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        q_bit = (trial >= t_trial'(r_dsr));
        n_rem = q_bit ? t_win'(trial - t_trial'(r_dsr)) : trial[WIN_W-1:0];
    end

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hdl/averaged_hysteresis_threshold.sv
// Top level: moving-average filter with single or hysteresis threshold classifier.
//
// Usage:
//   i_in carries one item per handshake: cmd and a 16-bit sample. cmd 1 loads the
//   programmed initial state (level all ones if on, zero if off). o_out returns one
//   item per input item: level, switch_state and changed. Registers are written
//   through i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so only while idle, as the block does not check.
// Flow:
//   A filtered sample passes the ring and sum update, a divider start, 20 steps
//   of the bit-serial divider, a done pulse and the classify step into the
//   output register. Raw samples and commands go from accept straight to the
//   classify step and the output register. The next item can be accepted in
//   the cycle in which the result appears. i_in.ready is high only while idle.
// Reset: clears the ring (through per-entry valid bits), sum, position,
//   switch state, output valid, sequencer state and configuration registers to their defaults.
// Stall: a result waits in the output register; the next item is accepted
//   meanwhile and its result is held in the classify step until the slot frees.
module averaged_hysteresis_threshold (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    aht_in_if.sink                         i_in,
    aht_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [aht_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [aht_pkg::CFG_W-1:0]      i_cfg_data
);
    import aht_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_CLS  = 4'b1000
    } t_state;

    // Configuration registers
    logic   r_filter_on;
    t_win   r_window_size;
    t_mode  r_event_mode;
    t_level r_single_thr;
    t_level r_low_thr;
    t_level r_high_thr;
    logic   r_init_state;

    // Sequencer and item state
    t_state r_state, n_state;
    logic   r_cmd;
    t_level r_lvl;
    logic   r_div_start;
    logic   r_cur_state;

    // Output register
    logic   r_out_valid;
    t_level r_out_level;
    logic   r_out_state;
    logic   r_out_chg;

    t_win   win_eff;
    t_sum   ring_sum;
    logic   div_done;
    t_sum   div_q;
    t_level q_sat;
    logic   in_acc;
    logic   slot_free;
    logic   cls_fire;
    logic   cls_state;
    logic   cls_chg;
    t_level cls_level;

    assign win_eff   = eff_window(r_window_size);
    assign in_acc    = i_in.valid && i_in.ready;
    assign slot_free = !r_out_valid || o_out.ready;
    assign cls_fire  = (r_state == ST_CLS) && slot_free;
    assign q_sat     = (div_q > t_sum'(LEVEL_MAX)) ? LEVEL_MAX : div_q[SAMPLE_W-1:0];

    aht_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (r_state == ST_UPD),
        .i_sample (r_lvl),
        .i_window (win_eff),
        .o_sum    (ring_sum)
    );

    aht_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (ring_sum),
        .i_divisor  (win_eff),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_on   <= 1'b0;
            r_window_size <= t_win'(1);
            r_event_mode  <= MODE_NONE;
            r_single_thr  <= '0;
            r_low_thr     <= '0;
            r_high_thr    <= '0;
            r_init_state  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILTER_ON:   r_filter_on   <= i_cfg_data[0];
                CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[WIN_W-1:0];
                CFG_EVENT_MODE:  r_event_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_SINGLE_THR:  r_single_thr  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_LOW_THR:     r_low_thr     <= i_cfg_data[SAMPLE_W-1:0];
                CFG_HIGH_THR:    r_high_thr    <= i_cfg_data[SAMPLE_W-1:0];
                CFG_INIT_STATE:  r_init_state  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Classify the finished level, or load the initial state on a command
    always_comb begin
        cls_state = r_cur_state;
        cls_level = r_lvl;
        cls_chg   = 1'b0;
        if (r_cmd) begin
            cls_state = r_init_state;
            cls_level = r_init_state ? LEVEL_MAX : '0;
        end else begin
            case (r_event_mode)
                MODE_SINGLE: begin
                    cls_state = (r_lvl >= r_single_thr);
                end
                MODE_HYST: begin
                    if (r_lvl <= r_low_thr) begin
                        cls_state = 1'b0;
                    end else if (r_lvl >= r_high_thr) begin
                        cls_state = 1'b1;
                    end
                end
                default: ;
            endcase
            cls_chg = (cls_state != r_cur_state);
        end
    end

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (!i_in.cmd && r_filter_on) ? ST_UPD : ST_CLS;
                end
            end
            ST_UPD: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_CLS;
                end
            end
            ST_CLS: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Advance the sequencer and hold item control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_cur_state <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= (r_state == ST_UPD);
            if (cls_fire) begin
                r_cur_state <= cls_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload and output payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_in.cmd;
            r_lvl <= i_in.sample;
        end else if ((r_state == ST_DIV) && div_done) begin
            r_lvl <= q_sat;
        end
        if (cls_fire) begin
            r_out_level <= cls_level;
            r_out_state <= cls_state;
            r_out_chg   <= cls_chg;
        end
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.level        = r_out_level;
    assign o_out.switch_state = r_out_state;
    assign o_out.changed      = r_out_chg;

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside the divide step");

    // Raw sample or command goes straight to classify
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.cmd || !r_filter_on)) |=> (r_state == ST_CLS))
        else $error("bypass item did not go to classify");

    // A classify step with a free slot presents a result next cycle
    a_cls_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cls_fire |=> o_out.valid)
        else $error("classified item missing at the output");

    // A change is flagged only when a classifying mode is set
    a_chg_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.changed) |->
            ((r_event_mode == MODE_SINGLE) || (r_event_mode == MODE_HYST)))
        else $error("change flagged without classification");

endmodule
